// File: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/icg_pkg.sv
package icg_pkg;

  localparam logic [1:0] MODE_RAINBOW = 2'd1;
  localparam logic [1:0] MODE_BLUE    = 2'd2;

  localparam logic [1:0] REG_PALETTE_MODE = 2'd0;
  localparam logic [1:0] REG_MAX_ITER     = 2'd1;
  localparam logic [1:0] REG_INTERIOR     = 2'd2;

  localparam logic [1:0]  PALETTE_RESET  = MODE_RAINBOW;
  localparam logic [15:0] MAX_ITER_RESET = 16'd100;
  localparam logic [23:0] INTERIOR_RESET = 24'h00008B;

  localparam logic [7:0] CH_MAX      = 8'hFF;
  localparam logic [7:0] BLUE_BASE   = 8'd51;
  localparam logic [7:0] BLUE_SPAN   = 8'd204;
  localparam logic [7:0] NEON_R_MID  = 8'h9B;
  localparam logic [7:0] NEON_G_MID  = 8'h30;
  localparam logic [7:0] NEON_G_END  = 8'h14;
  localparam logic [7:0] NEON_B_END  = 8'h93;

  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] interior;
  } cfg_t;

endpackage

// File: src/icg_div_cell.sv
`include "assert_macros.svh"

module icg_div_cell #(
  parameter int REM_BITS = 16,
  parameter int Q_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [REM_BITS-1:0] up_rem,
  input  logic [Q_BITS-1:0]   up_quo,
  input  logic                up_interior,
  input  logic [REM_BITS-1:0] divisor,
  output logic                down_valid,
  input  logic                down_ready,
  output logic [REM_BITS-1:0] down_rem,
  output logic [Q_BITS-1:0]   down_quo,
  output logic                down_interior
);

  logic                v_r;
  logic [REM_BITS-1:0] rem_r;
  logic [Q_BITS-1:0]   quo_r;
  logic                int_r;

  logic [REM_BITS:0]   dbl;
  logic [REM_BITS:0]   diff;
  logic                fits;
  logic [REM_BITS-1:0] rem_nxt;
  logic [Q_BITS-1:0]   quo_nxt;

  always_comb begin
    dbl     = {up_rem, 1'b0};
    diff    = dbl - {1'b0, divisor};
    fits    = dbl >= {1'b0, divisor};
    rem_nxt = fits ? diff[REM_BITS-1:0] : dbl[REM_BITS-1:0];
    quo_nxt = {up_quo[Q_BITS-2:0], fits};
  end

  assign up_ready      = !v_r || down_ready;
  assign down_valid    = v_r;
  assign down_rem      = rem_r;
  assign down_quo      = quo_r;
  assign down_interior = int_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      int_r <= up_interior;
    end
  end

  `ASSERT_NEXT(a_load_fills, clk, rst_n, up_valid && up_ready, v_r)
  `ASSERT_NEXT(a_stall_holds, clk, rst_n, v_r && !down_ready, v_r && $stable({rem_r, quo_r, int_r}))
  `ASSERT_NEXT(a_bubble_moves, clk, rst_n, v_r && down_ready && !up_valid, !v_r)

endmodule

// File: src/icg_color.sv
`include "assert_macros.svh"

module icg_color
  import icg_pkg::*;
#(
  parameter int F = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  logic         up_valid,
  output logic         up_ready,
  input  logic [F-1:0] up_q,
  input  logic         up_interior,
  output logic         down_valid,
  input  logic         down_ready,
  output logic [23:0]  down_pixel
);

  localparam int TW = F + 3;
  localparam int PW = F + 8;
  localparam logic [2:0] SEG_RED_YELLOW   = 3'd0;
  localparam logic [2:0] SEG_YELLOW_GREEN = 3'd1;
  localparam logic [2:0] SEG_GREEN_CYAN   = 3'd2;
  localparam logic [2:0] SEG_CYAN_BLUE    = 3'd3;

  logic          v1_r;
  logic [F-1:0]  q1_r;
  logic [TW-1:0] t1_r;
  logic          int1_r;
  logic          v2_r;
  logic [23:0]   pix_r;
  logic          ready1;

  logic [TW-1:0] t_nxt;
  logic [2:0]    seg;
  logic [PW-1:0] fade_p;
  logic [7:0]    c;
  logic [PW-1:0] rg_p;
  logic [PW-1:0] bb_p;
  logic [F-1:0]  s;
  logic [F:0]    s_rest;
  logic [PW-1:0] nr_p;
  logic [PW-1:0] ng_p;
  logic [PW-1:0] nb_p;
  logic [7:0]    nr;
  logic [7:0]    ng;
  logic [7:0]    nb;
  logic [23:0]   rainbow;
  logic [23:0]   pix_nxt;

  assign t_nxt = TW'({up_q, 2'b00}) + TW'(up_q);

  assign ready1     = !v2_r || down_ready;
  assign up_ready   = !v1_r || ready1;
  assign down_valid = v2_r;
  assign down_pixel = pix_r;

  always_comb begin
    seg    = t1_r[TW-1:F];
    fade_p = {t1_r[F-1:0], 8'd0} - PW'(t1_r[F-1:0]);
    c      = fade_p[PW-1:F];
    case (seg)
      SEG_RED_YELLOW:   rainbow = {CH_MAX, c, 8'd0};
      SEG_YELLOW_GREEN: rainbow = {CH_MAX - c, CH_MAX, 8'd0};
      SEG_GREEN_CYAN:   rainbow = {8'd0, CH_MAX, c};
      SEG_CYAN_BLUE:    rainbow = {8'd0, CH_MAX - c, CH_MAX};
      default:          rainbow = {c, 8'd0, CH_MAX};
    endcase

    rg_p = {q1_r, 8'd0} - PW'(q1_r);
    bb_p = PW'(q1_r) * PW'(BLUE_SPAN);

    s      = {q1_r[F-2:0], 1'b0};
    s_rest = {1'b1, {F{1'b0}}} - {1'b0, s};
    if (!q1_r[F-1]) begin
      nr_p = PW'(s) * PW'(NEON_R_MID);
      ng_p = PW'(s) * PW'(NEON_G_MID);
      nb_p = {s, 8'd0} - PW'(s);
      nr   = nr_p[PW-1:F];
      ng   = ng_p[PW-1:F];
      nb   = nb_p[PW-1:F];
    end else begin
      nr_p = PW'(s) * PW'(CH_MAX - NEON_R_MID);
      ng_p = PW'(s_rest) * PW'(NEON_G_MID - NEON_G_END);
      nb_p = PW'(s) * PW'(CH_MAX - NEON_B_END) + PW'({F{1'b1}});
      nr   = NEON_R_MID + nr_p[PW-1:F];
      ng   = NEON_G_END + ng_p[PW-1:F];
      nb   = CH_MAX - nb_p[PW-1:F];
    end

    if (int1_r) begin
      pix_nxt = (cfg.mode == MODE_RAINBOW) ? cfg.interior : 24'd0;
    end else if (cfg.mode == MODE_RAINBOW) begin
      pix_nxt = rainbow;
    end else if (cfg.mode == MODE_BLUE) begin
      pix_nxt = {rg_p[PW-1:F], rg_p[PW-1:F], BLUE_BASE + bb_p[PW-1:F]};
    end else begin
      pix_nxt = {nr, ng, nb};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (up_ready) begin
        v1_r <= up_valid;
      end
      if (ready1) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      q1_r   <= up_q;
      t1_r   <= t_nxt;
      int1_r <= up_interior;
    end
    if (v1_r && ready1) begin
      pix_r <= pix_nxt;
    end
  end

  `ASSERT_IMPL(a_segment_range, clk, rst_n, v1_r, t1_r[TW-1:F] <= 3'd4)
  `ASSERT_NEXT(a_out_holds, clk, rst_n, v2_r && !down_ready, v2_r && $stable(pix_r))
  `ASSERT_NEXT(a_stage_moves, clk, rst_n, v1_r && ready1, v2_r)

endmodule

// File: src/iteration_count_color_gradient_core.sv
// Escape-time color gradient. Each input word carries one pixel's iteration
// count and yields one 24-bit RGB word. The block takes one word per clock and
// keeps taking words while a finished result waits until all FRACTION_BITS + 2
// stages hold a word, since every stage holds its own valid bit. The ratio
// count / max_iterations comes out of a chain of FRACTION_BITS restoring
// divider cells, one quotient bit per cell, followed by two palette stages.
// No word is taken during reset.
// Registers: palette_mode at 0x0, max_iterations at 0x4, and the rainbow
// interior color at 0x8. Write them only while no word is in flight.
module iteration_count_color_gradient_core
  import icg_pkg::*;
#(
  parameter int COUNT_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COUNT_BITS-1:0] in_iteration_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [23:0]           out_pixel_rgb
);

  localparam int MAX_BITS = (COUNT_BITS < 16) ? COUNT_BITS : 16;
  localparam int F = FRACTION_BITS;

  logic [1:0]          mode_r;
  logic [MAX_BITS-1:0] max_r;
  logic [23:0]         interior_r;
  logic [1:0]          reg_idx;
  cfg_t                cfg;

  logic                stg_v   [F+1];
  logic                stg_rdy [F+1];
  logic [MAX_BITS-1:0] stg_rem [F+1];
  logic [F-1:0]        stg_quo [F+1];
  logic                stg_int [F+1];

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= PALETTE_RESET;
      max_r      <= MAX_ITER_RESET[MAX_BITS-1:0];
      interior_r <= INTERIOR_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_PALETTE_MODE: mode_r     <= pwdata[1:0];
        REG_MAX_ITER:     max_r      <= pwdata[MAX_BITS-1:0];
        REG_INTERIOR:     interior_r <= pwdata[23:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PALETTE_MODE: prdata = {30'd0, mode_r};
      REG_MAX_ITER:     prdata = 32'(max_r);
      REG_INTERIOR:     prdata = {8'd0, interior_r};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg.mode     = mode_r;
  assign cfg.interior = interior_r;

  assign stg_v[0]   = in_valid;
  assign in_ready   = stg_rdy[0] && rst_n;
  assign stg_rem[0] = in_iteration_count[MAX_BITS-1:0];
  assign stg_quo[0] = '0;
  assign stg_int[0] = in_iteration_count >= COUNT_BITS'(max_r);

  for (genvar i = 0; i < F; i++) begin : g_cell
    icg_div_cell #(
      .REM_BITS(MAX_BITS),
      .Q_BITS  (F)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .up_valid     (stg_v[i]),
      .up_ready     (stg_rdy[i]),
      .up_rem       (stg_rem[i]),
      .up_quo       (stg_quo[i]),
      .up_interior  (stg_int[i]),
      .divisor      (max_r),
      .down_valid   (stg_v[i+1]),
      .down_ready   (stg_rdy[i+1]),
      .down_rem     (stg_rem[i+1]),
      .down_quo     (stg_quo[i+1]),
      .down_interior(stg_int[i+1])
    );
  end

  icg_color #(
    .F(F)
  ) u_color (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .up_valid   (stg_v[F]),
    .up_ready   (stg_rdy[F]),
    .up_q       (stg_quo[F]),
    .up_interior(stg_int[F]),
    .down_valid (out_valid),
    .down_ready (out_ready),
    .down_pixel (out_pixel_rgb)
  );

endmodule
